@@ design/tes_pkg.sv @@
`timescale 1ns / 1ps

package tes_pkg;

    // Sample and weight widths and the widths that follow from them.
    localparam int SAMPLE_BITS = 16;
    localparam int FAR_BITS    = SAMPLE_BITS + 1;
    localparam int CFG_BITS    = 17;
    localparam int WN_BITS     = CFG_BITS + 1;
    localparam int WF_BITS     = CFG_BITS;
    localparam int FRAC_BITS   = 17;
    localparam int ACC_BITS    = WN_BITS + SAMPLE_BITS + 1;
    localparam int Q_BITS      = ACC_BITS - FRAC_BITS;

    // Center weights in units of 2^-16; the pass weight in units of 2^-17.
    localparam logic [CFG_BITS-1:0] WEIGHT_ONE   = CFG_BITS'(65536);
    localparam logic [CFG_BITS-1:0] WEIGHT_RESET = CFG_BITS'(32768);
    localparam logic [WN_BITS-1:0]  PASS_WEIGHT  = WN_BITS'(1) << FRAC_BITS;

    // Kind of output a task computes.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PASS = 2'd0;
    localparam kind_t KIND_EDGE = 2'd1;
    localparam kind_t KIND_MID  = 2'd2;

    // One result to compute: near tap times its weight plus far tap times its weight.
    typedef struct packed {
        kind_t                         kind;
        logic signed [SAMPLE_BITS-1:0] near;
        logic signed [FAR_BITS-1:0]    far;
        logic                          last;
    } task_t;

    // Registered partial products of one result.
    typedef struct packed {
        logic signed [ACC_BITS-1:0] p_near;
        logic signed [ACC_BITS-1:0] p_far;
        logic                       last;
    } prod_t;

endpackage

@@ design/tes_window.sv @@
`timescale 1ns / 1ps

module tes_window (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   line_end,
    output logic                                   task_valid,
    input  logic                                   task_ready,
    output tes_pkg::task_t                         task_out
);

    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_TWO   = 2'd2;

    logic [1:0]                            fill_reg, fill_next;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] older_reg, older_next;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] newer_reg, newer_next;
    logic                                  a_valid_reg, a_valid_next;
    logic                                  b_valid_reg, b_valid_next;
    tes_pkg::task_t                        a_task_reg, a_task_next;
    tes_pkg::task_t                        b_task_reg, b_task_next;
    logic                                  accept;
    logic                                  task_fire;

    assign task_valid = a_valid_reg || b_valid_reg;
    assign task_out   = a_valid_reg ? a_task_reg : b_task_reg;
    assign task_fire  = task_valid && task_ready;

    // The slot takes a new word once everything it holds is issued by the end of this cycle.
    assign in_ready = !task_valid || (task_fire && !(a_valid_reg && b_valid_reg));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        fill_next    = fill_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_task_next  = a_task_reg;
        b_task_next  = b_task_reg;

        if (task_fire)
        begin
            if (a_valid_reg)
            begin
                a_valid_next = 1'b0;
            end
            else
            begin
                b_valid_next = 1'b0;
            end
        end

        if (accept)
        begin
            // The closing edge result, used whenever a line of two or more ends here.
            b_task_next.kind = tes_pkg::KIND_EDGE;
            b_task_next.near = sample_in;
            b_task_next.far  = {newer_reg[tes_pkg::SAMPLE_BITS-1], newer_reg};
            b_task_next.last = 1'b1;
            a_task_next.last = 1'b0;
            case (fill_reg)
                FILL_EMPTY:
                begin
                    a_task_next.kind = tes_pkg::KIND_PASS;
                    a_task_next.near = sample_in;
                    a_task_next.far  = '0;
                    a_task_next.last = 1'b1;
                end
                FILL_ONE:
                begin
                    a_task_next.kind = tes_pkg::KIND_EDGE;
                    a_task_next.near = newer_reg;
                    a_task_next.far  = {sample_in[tes_pkg::SAMPLE_BITS-1], sample_in};
                end
                default:
                begin
                    a_task_next.kind = tes_pkg::KIND_MID;
                    a_task_next.near = newer_reg;
                    a_task_next.far  = {older_reg[tes_pkg::SAMPLE_BITS-1], older_reg}
                                     + {sample_in[tes_pkg::SAMPLE_BITS-1], sample_in};
                end
            endcase

            if (fill_reg == FILL_EMPTY)
            begin
                a_valid_next = line_end;
                b_valid_next = 1'b0;
            end
            else
            begin
                a_valid_next = 1'b1;
                b_valid_next = line_end;
            end

            older_next = newer_reg;
            newer_next = sample_in;
            if (line_end)
            begin
                fill_next = FILL_EMPTY;
            end
            else if (fill_reg == FILL_EMPTY)
            begin
                fill_next = FILL_ONE;
            end
            else
            begin
                fill_next = FILL_TWO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= FILL_EMPTY;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        older_reg  <= older_next;
        newer_reg  <= newer_next;
        a_task_reg <= a_task_next;
        b_task_reg <= b_task_next;
    end

endmodule

@@ design/tes_mult.sv @@
`timescale 1ns / 1ps

module tes_mult (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tes_pkg::CFG_BITS-1:0]     center_weight,
    input  logic                             task_valid,
    output logic                             task_ready,
    input  tes_pkg::task_t                   task_in,
    output logic                             prod_valid,
    input  logic                             prod_ready,
    output tes_pkg::prod_t                   prod_out
);

    logic [tes_pkg::CFG_BITS-1:0]        c_lim;
    logic [tes_pkg::WN_BITS-1:0]         wn;
    logic [tes_pkg::WF_BITS-1:0]         wf;
    logic signed [tes_pkg::WN_BITS:0]    wn_s;
    logic signed [tes_pkg::WF_BITS:0]    wf_s;
    logic signed [tes_pkg::ACC_BITS-1:0] p_near;
    logic signed [tes_pkg::ACC_BITS-1:0] p_far;
    logic                                valid_reg, valid_next;
    tes_pkg::prod_t                      prod_reg, prod_next;

    // A center weight above one acts as one.
    assign c_lim = (center_weight > tes_pkg::WEIGHT_ONE) ? tes_pkg::WEIGHT_ONE : center_weight;

    always_comb
    begin
        case (task_in.kind)
            tes_pkg::KIND_EDGE:
            begin
                wn = {1'b0, tes_pkg::WEIGHT_ONE} + {1'b0, c_lim};
                wf = tes_pkg::WEIGHT_ONE - c_lim;
            end
            tes_pkg::KIND_MID:
            begin
                wn = {c_lim, 1'b0};
                wf = tes_pkg::WEIGHT_ONE - c_lim;
            end
            default:
            begin
                wn = tes_pkg::PASS_WEIGHT;
                wf = '0;
            end
        endcase
    end

    assign wn_s   = $signed({1'b0, wn});
    assign wf_s   = $signed({1'b0, wf});
    assign p_near = wn_s * task_in.near;
    assign p_far  = wf_s * task_in.far;

    assign task_ready = !valid_reg || prod_ready;
    assign prod_valid = valid_reg;
    assign prod_out   = prod_reg;

    always_comb
    begin
        valid_next = valid_reg;
        prod_next  = prod_reg;
        if (task_ready)
        begin
            valid_next       = task_valid;
            prod_next.p_near = p_near;
            prod_next.p_far  = p_far;
            prod_next.last   = task_in.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

@@ design/tes_finish.sv @@
`timescale 1ns / 1ps

module tes_finish (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   prod_valid,
    output logic                                   prod_ready,
    input  tes_pkg::prod_t                         prod_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   out_last
);

    localparam logic [tes_pkg::ACC_BITS-1:0] ROUND_HALF =
        tes_pkg::ACC_BITS'(1) << (tes_pkg::FRAC_BITS - 1);

    logic signed [tes_pkg::ACC_BITS-1:0]    acc;
    logic signed [tes_pkg::Q_BITS-1:0]      q;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] sat;
    logic                                   fits;
    logic                                   valid_reg, valid_next;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                                   last_reg, last_next;

    // Round half up, then floor by the arithmetic shift.
    assign acc  = prod_in.p_near + prod_in.p_far + $signed(ROUND_HALF);
    assign q    = acc[tes_pkg::ACC_BITS-1:tes_pkg::FRAC_BITS];
    assign fits = (q[tes_pkg::Q_BITS-1:tes_pkg::SAMPLE_BITS-1] == '0)
               || (q[tes_pkg::Q_BITS-1:tes_pkg::SAMPLE_BITS-1] == '1);

    always_comb
    begin
        if (fits)
        begin
            sat = q[tes_pkg::SAMPLE_BITS-1:0];
        end
        else if (q[tes_pkg::Q_BITS-1])
        begin
            sat = {1'b1, {(tes_pkg::SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(tes_pkg::SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign prod_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign sample_out = sample_reg;
    assign out_last   = last_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        sample_next = sample_reg;
        last_next   = last_reg;
        if (prod_ready)
        begin
            valid_next  = prod_valid;
            sample_next = sat;
            last_next   = prod_in.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
    end

endmodule

@@ design/three_tap_edge_smoother_top.sv @@
// Three-tap line smoother. Input words (sample_in, line_end) arrive on the
// in_valid/in_ready channel, one line of samples at a time, line_end set on the
// last word of each line. Result words (sample_out, out_last) leave on the
// out_valid/out_ready channel, out_last set on the last result of a line.
// Each input word releases the result for the sample before it; the word that
// ends a line releases two, and a line of one sample passes through unchanged.
// The center weight is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
// It takes effect for the next word. A result word passes through the window
// slot, the product register and the output register; the second result of
// a line's last word follows the first. Throughput: one word per cycle while
// out_ready stays high. A word that ends a line of two or more samples holds
// in_ready low while both its results wait in the slot, since they leave at
// most one per cycle through the single multiply-and-round pipeline.
// Reset clears the line position, empties every stage and sets the center
// weight to one half. When the receiver stalls, each stage holds its word and
// in_ready falls once the window slot is full; nothing is dropped.
`timescale 1ns / 1ps

module three_tap_edge_smoother_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [tes_pkg::CFG_BITS-1:0]           cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   line_end,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   out_last
);

    logic [tes_pkg::CFG_BITS-1:0] center_weight_reg, center_weight_next;
    logic                         task_valid;
    logic                         task_ready;
    tes_pkg::task_t               task_word;
    logic                         prod_valid;
    logic                         prod_ready;
    tes_pkg::prod_t               prod_word;

    // The user must write the weight register only between lines (the block does
    // not enforce this), so it needs no shadow copy for words already in flight.
    assign center_weight_next = cfg_wr_en ? cfg_wr_data : center_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_weight_reg <= tes_pkg::WEIGHT_RESET;
        end
        else
        begin
            center_weight_reg <= center_weight_next;
        end
    end

    // Two-sample window and a slot that holds the one or two results a word releases.
    tes_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .line_end   (line_end),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .task_out   (task_word)
    );

    // Weight selection and the two products, registered.
    tes_mult u_mult (
        .clk           (clk),
        .rst_n         (rst_n),
        .center_weight (center_weight_reg),
        .task_valid    (task_valid),
        .task_ready    (task_ready),
        .task_in       (task_word),
        .prod_valid    (prod_valid),
        .prod_ready    (prod_ready),
        .prod_out      (prod_word)
    );

    // Sum, rounding and saturation into the output register.
    tes_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_in    (prod_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .out_last   (out_last)
    );

`ifndef SYNTHESIS
    // Input is only refused while the slot still has a result to issue.
    a_ready_low_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> task_valid)
        else $error("in_ready low with an empty window slot");

    // A task that the product stage refuses stays put for the next cycle.
    a_task_holds: assert property (@(posedge clk) disable iff (!rst_n)
        task_valid && !task_ready |=> task_valid && $stable(task_word))
        else $error("window task changed while stalled");

    // Products held back by the output register are not overwritten.
    a_prod_holds: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid && !prod_ready |=> prod_valid && $stable(prod_word))
        else $error("product register changed while stalled");
`endif

endmodule
